// ----- src/fad_pkg.sv -----
// fad_pkg: shared types and constants for the free agent dispatcher.
// No dependencies; fad_regs, fad_ctrl, fad_dp and the top use scoped names.
`default_nettype none
package fad_pkg;

  localparam int WORKERS_DEF    = 16;
  localparam int WAIT_DEPTH_DEF = 64;

  localparam int CMD_W   = 2;
  localparam int JOB_W   = 16;
  localparam int WIDX_W  = 4;
  localparam int TIME_W  = 32;
  localparam int WCNT_W  = 5;
  localparam int NACT_W  = 7;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_ARRIVE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FINISH   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TRANSFER = 2'd2;

  localparam logic REG_WORKER_COUNT = 1'b0;
  localparam logic [WCNT_W-1:0] WORKER_COUNT_RST = 5'd16;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [JOB_W-1:0]  job_id;
    logic [WIDX_W-1:0] worker_index;
    logic [TIME_W-1:0] event_time;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] out_time;
    logic [JOB_W-1:0]  out_job;
    logic [WIDX_W-1:0] out_worker;
    logic              dropped;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic has_result;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- src/fad_stream_if.sv -----
// fad_stream_if: valid/ready channel carrying one item of a given payload type.
// Used with fad_pkg::in_item_t and fad_pkg::out_item_t.
`default_nettype none
interface fad_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/free_agent_dispatcher.sv -----
// free_agent_dispatcher: hands jobs to a pool of workers, with a wait FIFO.
// Depends on fad_pkg, fad_stream_if, fad_regs, fad_ctrl, fad_dp, fad_ram.
//
// Usage:
//   in_if  (sink, fad_pkg::in_item_t): command 0 job arrives, 1 worker finished,
//          2 transfer request. An item is taken when valid and ready are high.
//   out_if (source, fad_pkg::out_item_t): at most one result item per input item,
//          giving the worker assigned or a dropped job, with the input time stamp.
//   APB port: register worker_count at byte address 0, written in the access
//          phase; pready is tied high. Write it only while the block is idle.
// Timing: an item is taken in the idle state and committed in the exec state;
//   no new item is taken until it is committed. A result is registered into
//   the output register at commit. The worker search and the wait-FIFO RAM
//   read of the head entry both resolve in the commit cycle.
// Stall: the output register holds one result. If it is still full when a
//   new item wants to report, the item waits in the commit stage and in_if
//   stays not ready until out_if takes the pending result.
// Reset (rst_n, synchronous): all workers idle, FIFO empty, worker_count 16.
`default_nettype none
module free_agent_dispatcher #(
  parameter int WORKERS    = fad_pkg::WORKERS_DEF,
  parameter int WAIT_DEPTH = fad_pkg::WAIT_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  fad_stream_if.sink                       in_if,
  fad_stream_if.source                     out_if,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fad_pkg::PADDR_W-1:0] paddr,
  input  wire logic [fad_pkg::PDATA_W-1:0] pwdata,
  output logic      [fad_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);
  logic [fad_pkg::WCNT_W-1:0] worker_count;
  fad_pkg::ctl_cmd_t          cmd;
  fad_pkg::dp_status_t        st;
  fad_pkg::in_item_t          in_data;
  fad_pkg::out_item_t         out_data;

  assign in_data = in_if.data;

  fad_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .worker_count (worker_count)
  );

  fad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .st       (st),
    .cmd      (cmd)
  );

  fad_dp #(
    .WORKERS    (WORKERS),
    .WAIT_DEPTH (WAIT_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .in_data      (in_data),
    .worker_count (worker_count),
    .out_valid    (out_if.valid),
    .out_ready    (out_if.ready),
    .out_data     (out_data)
  );

  assign out_if.data = out_data;
endmodule
`default_nettype wire

// ----- src/fad_ram.sv -----
// fad_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module fad_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/fad_regs.sv -----
// fad_regs: APB-style configuration register (worker_count).
// Depends on fad_pkg.
`default_nettype none
module fad_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fad_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [fad_pkg::PDATA_W-1:0]   pwdata,
  output logic      [fad_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  output logic      [fad_pkg::WCNT_W-1:0]    worker_count
);
  logic [fad_pkg::WCNT_W-1:0] worker_count_r;
  logic                       sel_wc;

  assign pready = 1'b1;
  assign sel_wc = (paddr[2] == fad_pkg::REG_WORKER_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      worker_count_r <= fad_pkg::WORKER_COUNT_RST;
    end else if (psel && penable && pwrite && pready && sel_wc) begin
      worker_count_r <= pwdata[fad_pkg::WCNT_W-1:0];
    end
  end

  assign prdata = sel_wc ? {{(fad_pkg::PDATA_W-fad_pkg::WCNT_W){1'b0}}, worker_count_r}
                         : '0;
  assign worker_count = worker_count_r;
endmodule
`default_nettype wire

// ----- src/fad_ctrl.sv -----
// fad_ctrl: two-state sequencer that takes one item and commits it.
// Depends on fad_pkg for the command and status structs.
`default_nettype none
module fad_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire fad_pkg::dp_status_t st,
  output fad_pkg::ctl_cmd_t        cmd
);
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.commit = (state_r == S_EXEC) && (!st.has_result || st.out_free);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_EXEC)
    else $error("accepted item did not start execution");
  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> state_r == S_IDLE && in_ready)
    else $error("commit did not return to idle");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && !cmd.commit) |=> state_r == S_EXEC && !in_ready)
    else $error("stalled item left execution");
endmodule
`default_nettype wire

// ----- src/fad_dp.sv -----
// fad_dp: worker table, wait FIFO and output register of the dispatcher.
// Depends on fad_pkg and fad_ram.
`default_nettype none
module fad_dp #(
  parameter int WORKERS    = fad_pkg::WORKERS_DEF,
  parameter int WAIT_DEPTH = fad_pkg::WAIT_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire fad_pkg::ctl_cmd_t          cmd,
  output fad_pkg::dp_status_t             st,
  input  wire fad_pkg::in_item_t          in_data,
  input  wire logic [fad_pkg::WCNT_W-1:0] worker_count,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output fad_pkg::out_item_t              out_data
);
  localparam int WI = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int AW = $clog2(WAIT_DEPTH);
  localparam int CW = $clog2(WAIT_DEPTH + 1);
  localparam int JW = fad_pkg::JOB_W;
  localparam int NW = fad_pkg::NACT_W;

  fad_pkg::in_item_t  req_r;
  fad_pkg::out_item_t out_data_r;
  logic               out_valid_r;
  logic               busy_r [WORKERS];
  logic [JW-1:0]      job_r  [WORKERS];
  logic [AW-1:0]      head_r, tail_r;
  logic [CW-1:0]      count_r;

  logic [NW-1:0] n_act;
  logic          idle_hit, xfer_hit, finish_ok, fifo_full, fifo_empty;
  logic [WI-1:0] idle_idx, xfer_idx, widx;
  logic [JW-1:0] head_job;

  logic          has_res, res_drop, push, pop;
  logic [WI-1:0] res_idx;
  logic [JW-1:0] res_job;
  logic          upd_en, upd_busy;
  logic [WI-1:0] upd_idx;
  logic [JW-1:0] upd_job;

  assign n_act = ({2'b00, worker_count} > NW'(WORKERS)) ? NW'(WORKERS)
                                                         : {2'b00, worker_count};
  assign widx       = WI'(req_r.worker_index);
  assign finish_ok  = ({3'b000, req_r.worker_index} < n_act);
  assign fifo_full  = (count_r == CW'(WAIT_DEPTH));
  assign fifo_empty = (count_r == '0);

  always_comb begin
    idle_hit = 1'b0;
    idle_idx = '0;
    for (int j = WORKERS - 1; j >= 0; j--) begin
      if ((NW'(j) < n_act) && !busy_r[j]) begin
        idle_hit = 1'b1;
        idle_idx = WI'(j);
      end
    end
  end

  always_comb begin
    xfer_hit = 1'b0;
    xfer_idx = '0;
    for (int j = 0; j < WORKERS; j++) begin
      if ((NW'(j) < n_act) && busy_r[j] && (job_r[j] == req_r.job_id)) begin
        xfer_hit = 1'b1;
        xfer_idx = WI'(j);
      end
    end
  end

  always_comb begin
    has_res  = 1'b0;
    res_drop = 1'b0;
    res_idx  = '0;
    res_job  = req_r.job_id;
    push     = 1'b0;
    pop      = 1'b0;
    upd_en   = 1'b0;
    upd_busy = 1'b0;
    upd_idx  = '0;
    upd_job  = '0;
    case (req_r.command)
      fad_pkg::CMD_ARRIVE: begin
        if (idle_hit) begin
          has_res  = 1'b1;
          res_idx  = idle_idx;
          upd_en   = 1'b1;
          upd_busy = 1'b1;
          upd_idx  = idle_idx;
          upd_job  = req_r.job_id;
        end else if (fifo_full) begin
          has_res  = 1'b1;
          res_drop = 1'b1;
        end else begin
          push = 1'b1;
        end
      end
      fad_pkg::CMD_FINISH: begin
        if (finish_ok) begin
          upd_en  = 1'b1;
          upd_idx = widx;
          if (!fifo_empty) begin
            pop      = 1'b1;
            has_res  = 1'b1;
            res_idx  = widx;
            res_job  = head_job;
            upd_busy = 1'b1;
            upd_job  = head_job;
          end
        end
      end
      fad_pkg::CMD_TRANSFER: begin
        if (xfer_hit) begin
          has_res = 1'b1;
          res_idx = xfer_idx;
        end
      end
      default: ;
    endcase
  end

  assign st.has_result = has_res;
  assign st.out_free   = !out_valid_r || out_ready;

  fad_ram #(
    .WIDTH (JW),
    .DEPTH (WAIT_DEPTH)
  ) u_wait_ram (
    .clk   (clk),
    .we    (cmd.commit && push),
    .waddr (tail_r),
    .wdata (req_r.job_id),
    .raddr (head_r),
    .rdata (head_job)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.commit && has_res) begin
      out_data_r.out_time   <= req_r.event_time;
      out_data_r.out_job    <= res_job;
      out_data_r.out_worker <= fad_pkg::WIDX_W'(res_idx);
      out_data_r.dropped    <= res_drop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      for (int j = 0; j < WORKERS; j++) begin
        busy_r[j] <= 1'b0;
        job_r[j]  <= '0;
      end
    end else begin
      if (cmd.commit && has_res) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.commit) begin
        if (upd_en) begin
          busy_r[upd_idx] <= upd_busy;
          job_r[upd_idx]  <= upd_job;
        end
        if (push) begin
          tail_r  <= (tail_r == AW'(WAIT_DEPTH - 1)) ? '0 : tail_r + 1'b1;
          count_r <= count_r + 1'b1;
        end
        if (pop) begin
          head_r  <= (head_r == AW'(WAIT_DEPTH - 1)) ? '0 : head_r + 1'b1;
          count_r <= count_r - 1'b1;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(WAIT_DEPTH))
    else $error("wait FIFO count overflow");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CW'(WAIT_DEPTH)) |-> head_r == tail_r)
    else $error("wait FIFO pointers disagree with count");
  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && has_res) |=> out_valid_r)
    else $error("committed result not presented");
  a_count_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(count_r))
    else $error("wait FIFO changed without commit");
endmodule
`default_nettype wire

// ----- tb/sv/tb_free_agent_dispatcher.sv -----
// tb_free_agent_dispatcher: self-checking bench for the job dispatcher, with a
// worker/wait-FIFO predictor, queue-fed driver, result monitor and APB writes.
// Depends on fad_pkg, fad_stream_if and free_agent_dispatcher.
module tb_free_agent_dispatcher;
  timeunit 1ns;
  timeprecision 1ps;

  import fad_pkg::*;

  localparam int NUM_WORKERS   = WORKERS_DEF;
  localparam int FIFO_DEPTH    = WAIT_DEPTH_DEF;
  localparam int RUN_LIMIT     = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 300;
  localparam int JOB_POOL      = 24;
  localparam int MAX_REPORTS   = 40;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] WORKER_COUNT_ADDR = PADDR_W'(4 * int'(REG_WORKER_COUNT));

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  fad_stream_if #(.payload_t(in_item_t))  in_ch ();
  fad_stream_if #(.payload_t(out_item_t)) out_ch ();

  free_agent_dispatcher uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [WCNT_W-1:0] active_count_cfg;
  bit                busy_now [NUM_WORKERS];
  logic [JOB_W-1:0]  job_held [NUM_WORKERS];
  logic [JOB_W-1:0]  waiting_jobs[$];

  in_item_t  job_events[$];
  out_item_t expected_assignments[$];

  int events_queued = 0;
  int events_accepted = 0;
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit predict_dispatch(input in_item_t ev, output out_item_t res);
    int n;
    int j;
    int hit;
    logic [JOB_W-1:0] next_job;
    n = (active_count_cfg > NUM_WORKERS) ? NUM_WORKERS : int'(active_count_cfg);
    res = '0;
    res.out_time = ev.event_time;
    case (ev.command)
      CMD_ARRIVE: begin
        for (j = 0; j < n; j++) begin
          if (!busy_now[j]) begin
            busy_now[j] = 1'b1;
            job_held[j] = ev.job_id;
            res.out_job = ev.job_id;
            res.out_worker = WIDX_W'(j);
            return 1'b1;
          end
        end
        if (waiting_jobs.size() >= FIFO_DEPTH) begin
          res.out_job = ev.job_id;
          res.dropped = 1'b1;
          return 1'b1;
        end
        waiting_jobs.push_back(ev.job_id);
        return 1'b0;
      end
      CMD_FINISH: begin
        if (int'(ev.worker_index) >= n) return 1'b0;
        busy_now[ev.worker_index] = 1'b0;
        job_held[ev.worker_index] = '0;
        if (waiting_jobs.size() == 0) return 1'b0;
        next_job = waiting_jobs.pop_front();
        busy_now[ev.worker_index] = 1'b1;
        job_held[ev.worker_index] = next_job;
        res.out_job = next_job;
        res.out_worker = ev.worker_index;
        return 1'b1;
      end
      CMD_TRANSFER: begin
        hit = -1;
        for (j = 0; j < n; j++) begin
          if (busy_now[j] && job_held[j] == ev.job_id) hit = j;
        end
        if (hit < 0) return 1'b0;
        res.out_job = ev.job_id;
        res.out_worker = WIDX_W'(hit);
        return 1'b1;
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  function automatic in_item_t random_event(input int arrive_pct, input int finish_pct,
                                            input int xfer_pct, input int idx_span);
    in_item_t ev;
    int roll;
    roll = $urandom_range(99);
    ev.event_time = $urandom;
    ev.worker_index = WIDX_W'($urandom_range(15));
    // mostly a small id pool so transfers find their job and ids repeat
    ev.job_id = ($urandom_range(3) == 0) ? JOB_W'($urandom) : JOB_W'($urandom_range(JOB_POOL - 1));
    if (roll < arrive_pct) begin
      ev.command = CMD_ARRIVE;
    end else if (roll < arrive_pct + finish_pct) begin
      ev.command = CMD_FINISH;
      if (idx_span > 0 && $urandom_range(4) != 0)
        ev.worker_index = WIDX_W'($urandom_range(idx_span - 1));
    end else if (roll < arrive_pct + finish_pct + xfer_pct) begin
      ev.command = CMD_TRANSFER;
    end else begin
      ev.command = CMD_UNUSED;
    end
    return ev;
  endfunction

  task automatic push_event(input in_item_t ev);
    job_events.push_back(ev);
    events_queued++;
  endtask

  task automatic queue_event(input logic [CMD_W-1:0] cmd, input logic [JOB_W-1:0] job,
                             input logic [WIDX_W-1:0] idx, input logic [TIME_W-1:0] stamp);
    in_item_t ev;
    ev.command = cmd;
    ev.job_id = job;
    ev.worker_index = idx;
    ev.event_time = stamp;
    push_event(ev);
  endtask

  task automatic drain_block();
    do @(negedge clk);
    while (events_accepted != events_queued || expected_assignments.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_worker_count(input logic [WCNT_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= WORKER_COUNT_ADDR;
    pwdata <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    active_count_cfg = value;
  endtask

  task automatic set_phase(input int wc, input int s_idle, input int r_stall);
    drain_block();
    write_worker_count(WCNT_W'(wc));
    @(negedge clk);
    send_idle_pct = s_idle;
    recv_stall_pct = r_stall;
  endtask

  task automatic run_phase(input int count, input int wc, input int arr, input int fin,
                           input int xfer, input int s_idle, input int r_stall,
                           input bit long_hold);
    int span;
    set_phase(wc, s_idle, r_stall);
    if (long_hold) hold_requests++;
    span = (wc > NUM_WORKERS) ? NUM_WORKERS : wc;
    repeat (count) push_event(random_event(arr, fin, xfer, span));
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : event_driver
    out_item_t predicted;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        events_accepted++;
        if (predict_dispatch(in_ch.data, predicted)) expected_assignments.push_back(predicted);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (job_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.data <= job_events.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_assignments.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, got time %h job %h worker %0d drop %b",
                     $time, out_ch.data.out_time, out_ch.data.out_job,
                     out_ch.data.out_worker, out_ch.data.dropped);
        end else begin
          want = expected_assignments.pop_front();
          check_field("out_time", want.out_time, out_ch.data.out_time);
          check_field("out_job", 32'(want.out_job), 32'(out_ch.data.out_job));
          check_field("out_worker", 32'(want.out_worker), 32'(out_ch.data.out_worker));
          check_field("dropped", 32'(want.dropped), 32'(out_ch.data.dropped));
        end
      end
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    active_count_cfg = WORKER_COUNT_RST;
    for (int k = 0; k < NUM_WORKERS; k++) begin
      busy_now[k] = 1'b0;
      job_held[k] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset count: assignment order, duplicate ids, transfer search, idle finish
    queue_event(CMD_ARRIVE, 16'h0000, 4'd0, 32'h0000_0000);
    queue_event(CMD_ARRIVE, 16'hFFFF, 4'd15, 32'hFFFF_FFFF);
    queue_event(CMD_ARRIVE, 16'h0000, 4'd0, $urandom);
    queue_event(CMD_TRANSFER, 16'h0000, 4'd0, $urandom);
    queue_event(CMD_TRANSFER, 16'hFFFF, 4'd0, $urandom);
    queue_event(CMD_TRANSFER, 16'h1234, 4'd0, $urandom);
    queue_event(CMD_FINISH, 16'h0000, 4'd15, $urandom);
    queue_event(CMD_FINISH, 16'hFFFF, 4'd1, $urandom);
    queue_event(CMD_UNUSED, 16'h0005, 4'd3, $urandom);

    // one worker: queueing, out-of-range finish, hidden workers
    set_phase(1, 0, 0);
    queue_event(CMD_FINISH, 16'h0000, 4'd0, $urandom);
    queue_event(CMD_ARRIVE, 16'h0007, 4'd0, $urandom);
    queue_event(CMD_ARRIVE, 16'h0008, 4'd0, $urandom);
    queue_event(CMD_ARRIVE, 16'h0009, 4'd0, $urandom);
    queue_event(CMD_FINISH, 16'h0000, 4'd5, $urandom);
    queue_event(CMD_TRANSFER, 16'h0000, 4'd0, $urandom);
    queue_event(CMD_FINISH, 16'h0000, 4'd0, $urandom);

    // count above the pool size
    set_phase(31, 0, 0);
    queue_event(CMD_ARRIVE, 16'h000A, 4'd0, $urandom);
    queue_event(CMD_FINISH, 16'h0000, 4'd15, $urandom);
    queue_event(CMD_TRANSFER, 16'h0009, 4'd0, $urandom);

    // no workers in use
    set_phase(0, 0, 0);
    queue_event(CMD_ARRIVE, 16'h000B, 4'd0, $urandom);
    queue_event(CMD_FINISH, 16'h0000, 4'd0, $urandom);
    queue_event(CMD_TRANSFER, 16'h000A, 4'd0, $urandom);

    run_phase(260, 16, 50, 30, 15, 0, 0, 1'b0);
    run_phase(260, 1, 70, 15, 12, 67, 0, 1'b0);
    run_phase(260, 31, 45, 35, 15, 0, 67, 1'b0);
    run_phase(200, 0, 75, 12, 10, 30, 30, 1'b0);
    run_phase(300, 8, 50, 30, 15, 0, 0, 1'b1);
    run_phase(270, 16, 30, 55, 12, 30, 30, 1'b0);

    drain_block();
    if (mismatches == 0 && expected_assignments.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/fad_pkg.sv
src/fad_stream_if.sv
src/fad_ram.sv
src/fad_regs.sv
src/fad_ctrl.sv
src/fad_dp.sv
src/free_agent_dispatcher.sv
tb/sv/tb_free_agent_dispatcher.sv
